>>> hw/rtl/dpm_pkg.sv
// Shared types, constants and the region lookup for the paging MMU.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
package dpm_pkg;

  localparam int VPAGES    = 2048;
  localparam int VPN_W     = 11;
  localparam int FRAMES    = 32;
  localparam int FRAME_W   = 5;
  localparam int PAGE_BITS = 12;
  localparam int REGIONS   = 4;
  localparam int REG_W     = 22;
  localparam int PA_W      = 17;
  localparam int VA_W      = 23;
  localparam int STEP_W    = $clog2(FRAMES + 2);
  localparam int FLUSH_MAX = 32;
  localparam int FCNT_W    = $clog2(FLUSH_MAX + 1);

  localparam logic [2:0] ST_HIT   = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_INVAL = 3'd2;
  localparam logic [2:0] ST_WB    = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic FN_XLATE = 1'b0;
  localparam logic FN_FLUSH = 1'b1;

  localparam logic [2:0] CFG_MODE = 3'd0;
  localparam logic [2:0] CFG_RGN0 = 3'd1;
  localparam logic [2:0] CFG_RGN1 = 3'd2;
  localparam logic [2:0] CFG_RGN2 = 3'd3;
  localparam logic [2:0] CFG_RGN3 = 3'd4;

  localparam logic MODE_CLOCK = 1'b0;
  localparam logic MODE_FIFO  = 1'b1;

  typedef struct packed {
    logic            func;
    logic [VA_W-1:0] virt_addr;
    logic            write_op;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [PA_W-1:0]    phys_addr;
    logic [1:0]         load_region;
    logic [VPN_W-1:0]   load_page;
    logic               writeback_valid;
    logic [VPN_W-1:0]   writeback_vpn;
    logic [FRAME_W-1:0] writeback_frame;
    logic [1:0]         writeback_region;
    logic [VPN_W-1:0]   writeback_page;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic               v;
    logic               a;
    logic               d;
    logic [FRAME_W-1:0] frame;
  } pte_t;

  typedef struct packed {
    logic             valid;
    logic [VPN_W-1:0] vpn;
  } own_t;

  typedef struct packed {
    logic             rd_en;
    logic [VPN_W-1:0] rd_addr;
    logic             wr_en;
    logic [VPN_W-1:0] wr_addr;
    pte_t             wr_data;
  } pt_req_t;

  typedef struct packed {
    logic               rd_en;
    logic [FRAME_W-1:0] rd_addr;
    logic               own_we;
    logic [FRAME_W-1:0] own_waddr;
    own_t               own_wdata;
    logic               nxt_we;
    logic [FRAME_W-1:0] nxt_waddr;
    logic [FRAME_W-1:0] nxt_wdata;
    logic               prv_we;
    logic [FRAME_W-1:0] prv_waddr;
    logic [FRAME_W-1:0] prv_wdata;
  } fm_req_t;

  typedef struct packed {
    own_t               own;
    logic [FRAME_W-1:0] nxt;
    logic [FRAME_W-1:0] prv;
  } fm_rsp_t;

  typedef struct packed {
    logic             hit;
    logic [1:0]       idx;
    logic [VPN_W-1:0] page;
  } rgn_t;

  // Lowest-numbered matching region wins; a miss leaves region 0 and the raw page.
  function automatic rgn_t find_region(input logic [VPN_W-1:0] vpn,
                                       input logic [REGIONS-1:0][REG_W-1:0] rg);
    rgn_t             res;
    logic [VPN_W-1:0] lo;
    logic [VPN_W-1:0] hi;
    res.hit  = 1'b0;
    res.idx  = 2'd0;
    res.page = vpn;
    for (int r = REGIONS - 1; r >= 0; r--) begin
      lo = rg[r][VPN_W-1:0];
      hi = rg[r][2*VPN_W-1:VPN_W];
      if (lo <= hi && vpn >= lo && vpn <= hi) begin
        res.hit  = 1'b1;
        res.idx  = 2'(r);
        res.page = vpn - lo;
      end
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/demand_paging_mmu_with_clock_fifo.sv
// Channel   Ports                            Moves
// input     in_valid/in_ready/in_data        one translate or flush request
// result    out_valid/out_ready/out_data     one result item, last marks the end
// config    cfg_valid/cfg_ready/cfg_index/   one register write, always ready
//           cfg_data
// A clock miss may step the hand up to 33 times before it picks a victim.
// A flush sweeps the 2048 page-table entries, stopping early after 32
// write-backs. After reset the page table is cleared one entry a cycle,
// with in_ready low. A stalled result holds the sequencer.
// Depends on dpm_pkg, dpm_page_table, dpm_frame_mem, dpm_ctrl.
`timescale 1ns / 1ps
module demand_paging_mmu_with_clock_fifo
  import dpm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  logic                          mode_r;
  logic [REGIONS-1:0][REG_W-1:0] region_r;
  pt_req_t                       pt_req;
  pte_t                          pt_rdata;
  fm_req_t                       fm_req;
  fm_rsp_t                       fm_rsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_CLOCK;
      region_r <= {REGIONS{REG_W'(1)}};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODE: mode_r      <= cfg_data[0];
        CFG_RGN0: region_r[0] <= cfg_data;
        CFG_RGN1: region_r[1] <= cfg_data;
        CFG_RGN2: region_r[2] <= cfg_data;
        CFG_RGN3: region_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  dpm_page_table u_pt (
    .clk   (clk),
    .req   (pt_req),
    .rdata (pt_rdata)
  );

  dpm_frame_mem u_fm (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fm_req),
    .rsp   (fm_rsp)
  );

  dpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mode      (mode_r),
    .regions   (region_r),
    .pt_req    (pt_req),
    .pt_rdata  (pt_rdata),
    .fm_req    (fm_req),
    .fm_rsp    (fm_rsp)
  );

endmodule

>>> hw/rtl/dpm_page_table.sv
// Page table RAM: one entry per virtual page, registered read.
// Depends on dpm_pkg.
`timescale 1ns / 1ps
module dpm_page_table
  import dpm_pkg::*;
(
  input  logic    clk,
  input  pt_req_t req,
  output pte_t    rdata
);

  pte_t mem [VPAGES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr];
    end
  end

endmodule

>>> hw/rtl/dpm_frame_mem.sv
// Per-frame owner, FIFO next and FIFO prev memories with written-flags
// that stand in for their reset contents. Depends on dpm_pkg.
`timescale 1ns / 1ps
module dpm_frame_mem
  import dpm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  fm_req_t req,
  output fm_rsp_t rsp
);

  own_t               own_mem [FRAMES];
  logic [FRAME_W-1:0] nxt_mem [FRAMES];
  logic [FRAME_W-1:0] prv_mem [FRAMES];

  logic [FRAMES-1:0]  own_ok_r;
  logic [FRAMES-1:0]  nxt_ok_r;
  logic [FRAMES-1:0]  prv_ok_r;

  own_t               own_q;
  logic [FRAME_W-1:0] nxt_q;
  logic [FRAME_W-1:0] prv_q;
  logic [FRAME_W-1:0] addr_q;
  logic               own_ok_q;
  logic               nxt_ok_q;
  logic               prv_ok_q;

  always_ff @(posedge clk) begin
    if (req.own_we) begin
      own_mem[req.own_waddr] <= req.own_wdata;
    end
    if (req.nxt_we) begin
      nxt_mem[req.nxt_waddr] <= req.nxt_wdata;
    end
    if (req.prv_we) begin
      prv_mem[req.prv_waddr] <= req.prv_wdata;
    end
    if (req.rd_en) begin
      own_q    <= own_mem[req.rd_addr];
      nxt_q    <= nxt_mem[req.rd_addr];
      prv_q    <= prv_mem[req.rd_addr];
      addr_q   <= req.rd_addr;
      own_ok_q <= own_ok_r[req.rd_addr];
      nxt_ok_q <= nxt_ok_r[req.rd_addr];
      prv_ok_q <= prv_ok_r[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ok_r <= '0;
      nxt_ok_r <= '0;
      prv_ok_r <= '0;
    end else begin
      if (req.own_we) begin
        own_ok_r[req.own_waddr] <= 1'b1;
      end
      if (req.nxt_we) begin
        nxt_ok_r[req.nxt_waddr] <= 1'b1;
      end
      if (req.prv_we) begin
        prv_ok_r[req.prv_waddr] <= 1'b1;
      end
    end
  end

  // Unwritten entries read as the ring 0..FRAMES-1 with every frame empty.
  always_comb begin
    rsp.own = own_ok_q ? own_q : '0;
    if (nxt_ok_q) begin
      rsp.nxt = nxt_q;
    end else if (addr_q == FRAME_W'(FRAMES - 1)) begin
      rsp.nxt = '0;
    end else begin
      rsp.nxt = addr_q + 1'b1;
    end
    if (prv_ok_q) begin
      rsp.prv = prv_q;
    end else if (addr_q == '0) begin
      rsp.prv = FRAME_W'(FRAMES - 1);
    end else begin
      rsp.prv = addr_q - 1'b1;
    end
  end

endmodule

>>> hw/rtl/dpm_ctrl.sv
// Sequencer: page table clear, translate, clock/FIFO victim choice, remap,
// FIFO relink and flush sweep, plus the output register. Depends on dpm_pkg.
`timescale 1ns / 1ps
module dpm_ctrl
  import dpm_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  in_item_t                      in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output out_item_t                     out_data,
  input  logic                          mode,
  input  logic [REGIONS-1:0][REG_W-1:0] regions,
  output pt_req_t                       pt_req,
  input  pte_t                          pt_rdata,
  output fm_req_t                       fm_req,
  input  fm_rsp_t                       fm_rsp
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_PT, S_FIFO_GET, S_CK_RD, S_CK_OWN, S_CK_PT,
    S_V_RD, S_V_OWN, S_V_OLD, S_V_MAP, S_V_RDT, S_V_LNK1, S_V_LNK2,
    S_F_RD, S_F_CHK, S_F_DONE
  } state_t;

  state_t                 state_r;
  logic [VPN_W-1:0]       vpn_r;
  logic [PAGE_BITS-1:0]   off_r;
  logic                   wr_r;
  logic [FRAME_W-1:0]     hand_r;
  logic [FRAME_W-1:0]     tail_r;
  logic [FRAME_W-1:0]     tailn_r;
  logic [FRAME_W-1:0]     victim_r;
  logic [FRAME_W-1:0]     p_r;
  logic [FRAME_W-1:0]     n_r;
  logic [VPN_W-1:0]       ovpn_r;
  logic [STEP_W-1:0]      steps_r;
  logic [VPN_W-1:0]       ptr_r;
  logic [FCNT_W-1:0]      fcnt_r;
  rgn_t                   lrgn_r;
  logic                   wbv_r;
  logic [VPN_W-1:0]       wbvpn_r;
  logic [FRAME_W-1:0]     wbframe_r;
  rgn_t                   wbrgn_r;
  logic                   out_valid_r;
  out_item_t              out_r;

  logic                   in_acc;
  logic                   out_free;
  logic                   emit;
  out_item_t              emit_d;
  rgn_t                   cur_rgn;
  rgn_t                   old_rgn;
  rgn_t                   fl_rgn;
  logic                   dirty;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cur_rgn   = find_region(vpn_r, regions);
  assign old_rgn   = find_region(ovpn_r, regions);
  assign fl_rgn    = find_region(ptr_r, regions);
  assign dirty     = pt_rdata.v && pt_rdata.d;

  always_comb begin
    pt_req = '0;
    fm_req = '0;
    emit   = 1'b0;
    emit_d = '0;
    unique case (state_r)
      S_CLR: begin
        pt_req.wr_en   = 1'b1;
        pt_req.wr_addr = ptr_r;
      end
      S_IDLE: begin
        pt_req.rd_en   = in_acc && (in_data.func == FN_XLATE);
        pt_req.rd_addr = in_data.virt_addr[PAGE_BITS +: VPN_W];
      end
      S_PT: begin
        fm_req.rd_en   = 1'b1;
        fm_req.rd_addr = tail_r;
        emit_d.last    = 1'b1;
        if (pt_rdata.v) begin
          emit             = 1'b1;
          emit_d.status    = ST_HIT;
          emit_d.phys_addr = {pt_rdata.frame, off_r};
          pt_req.wr_en     = 1'b1;
          pt_req.wr_addr   = vpn_r;
          pt_req.wr_data   = pt_rdata;
          pt_req.wr_data.a = 1'b1;
          pt_req.wr_data.d = pt_rdata.d | wr_r;
        end else if (!cur_rgn.hit) begin
          emit          = 1'b1;
          emit_d.status = ST_INVAL;
        end
      end
      S_FIFO_GET: ;
      S_CK_RD: begin
        fm_req.rd_en   = 1'b1;
        fm_req.rd_addr = hand_r;
      end
      S_CK_OWN: begin
        pt_req.rd_en   = fm_rsp.own.valid;
        pt_req.rd_addr = fm_rsp.own.vpn;
      end
      S_CK_PT: begin
        if (pt_rdata.a && steps_r <= STEP_W'(FRAMES)) begin
          pt_req.wr_en     = 1'b1;
          pt_req.wr_addr   = ovpn_r;
          pt_req.wr_data   = pt_rdata;
          pt_req.wr_data.a = 1'b0;
        end
      end
      S_V_RD: begin
        fm_req.rd_en   = 1'b1;
        fm_req.rd_addr = victim_r;
      end
      S_V_OWN: begin
        pt_req.rd_en   = fm_rsp.own.valid;
        pt_req.rd_addr = fm_rsp.own.vpn;
      end
      S_V_OLD: begin
        pt_req.wr_en   = 1'b1;
        pt_req.wr_addr = ovpn_r;
      end
      S_V_MAP: begin
        pt_req.wr_en         = 1'b1;
        pt_req.wr_addr       = vpn_r;
        pt_req.wr_data       = '{v: 1'b1, a: 1'b1, d: wr_r, frame: victim_r};
        fm_req.own_we        = 1'b1;
        fm_req.own_waddr     = victim_r;
        fm_req.own_wdata     = '{valid: 1'b1, vpn: vpn_r};
        // unlink the victim from its place in the ring
        fm_req.nxt_we        = 1'b1;
        fm_req.nxt_waddr     = p_r;
        fm_req.nxt_wdata     = n_r;
        fm_req.prv_we        = 1'b1;
        fm_req.prv_waddr     = n_r;
        fm_req.prv_wdata     = p_r;
      end
      S_V_RDT: begin
        fm_req.rd_en   = 1'b1;
        fm_req.rd_addr = tailn_r;
      end
      S_V_LNK1: begin
        fm_req.prv_we    = 1'b1;
        fm_req.prv_waddr = victim_r;
        fm_req.prv_wdata = fm_rsp.prv;
        fm_req.nxt_we    = 1'b1;
        fm_req.nxt_waddr = fm_rsp.prv;
        fm_req.nxt_wdata = victim_r;
      end
      S_V_LNK2: begin
        fm_req.nxt_we           = 1'b1;
        fm_req.nxt_waddr        = victim_r;
        fm_req.nxt_wdata        = tailn_r;
        fm_req.prv_we           = 1'b1;
        fm_req.prv_waddr        = tailn_r;
        fm_req.prv_wdata        = victim_r;
        emit                    = 1'b1;
        emit_d.status           = ST_LOAD;
        emit_d.phys_addr        = {victim_r, off_r};
        emit_d.load_region      = lrgn_r.idx;
        emit_d.load_page        = lrgn_r.page;
        emit_d.writeback_valid  = wbv_r;
        emit_d.writeback_vpn    = wbv_r ? wbvpn_r : '0;
        emit_d.writeback_frame  = wbv_r ? wbframe_r : '0;
        emit_d.writeback_region = wbv_r ? wbrgn_r.idx : '0;
        emit_d.writeback_page   = wbv_r ? wbrgn_r.page : '0;
        emit_d.last             = 1'b1;
      end
      S_F_RD: begin
        pt_req.rd_en   = 1'b1;
        pt_req.rd_addr = ptr_r;
      end
      S_F_CHK: begin
        if (dirty) begin
          emit                    = 1'b1;
          emit_d.status           = ST_WB;
          emit_d.writeback_valid  = 1'b1;
          emit_d.writeback_vpn    = ptr_r;
          emit_d.writeback_frame  = pt_rdata.frame;
          emit_d.writeback_region = fl_rgn.idx;
          emit_d.writeback_page   = fl_rgn.page;
          pt_req.wr_en            = 1'b1;
          pt_req.wr_addr          = ptr_r;
          pt_req.wr_data          = pt_rdata;
          pt_req.wr_data.d        = 1'b0;
        end
      end
      S_F_DONE: begin
        emit          = 1'b1;
        emit_d.status = ST_DONE;
        emit_d.last   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      ptr_r       <= '0;
      hand_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit && out_free) begin
        out_valid_r <= 1'b1;
        out_r       <= emit_d;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLR: begin
          ptr_r <= ptr_r + 1'b1;
          if (ptr_r == VPN_W'(VPAGES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            vpn_r <= in_data.virt_addr[PAGE_BITS +: VPN_W];
            off_r <= in_data.virt_addr[PAGE_BITS-1:0];
            wr_r  <= in_data.write_op;
            if (in_data.func == FN_FLUSH) begin
              ptr_r   <= '0;
              fcnt_r  <= '0;
              state_r <= S_F_RD;
            end else begin
              state_r <= S_PT;
            end
          end
        end
        S_PT: begin
          lrgn_r  <= cur_rgn;
          wbv_r   <= 1'b0;
          steps_r <= '0;
          if (emit) begin
            if (out_free) begin
              state_r <= S_IDLE;
            end
          end else if (mode == MODE_CLOCK) begin
            state_r <= S_CK_RD;
          end else begin
            state_r <= S_FIFO_GET;
          end
        end
        S_FIFO_GET: begin
          victim_r <= fm_rsp.prv;
          state_r  <= S_V_RD;
        end
        S_CK_RD: state_r <= S_CK_OWN;
        S_CK_OWN: begin
          ovpn_r <= fm_rsp.own.vpn;
          if (fm_rsp.own.valid) begin
            state_r <= S_CK_PT;
          end else begin
            victim_r <= hand_r;
            state_r  <= S_V_RD;
          end
        end
        S_CK_PT: begin
          if (pt_rdata.a && steps_r <= STEP_W'(FRAMES)) begin
            // second chance: clear the mark and advance the hand
            hand_r  <= (hand_r == FRAME_W'(FRAMES - 1)) ? '0 : hand_r + 1'b1;
            steps_r <= steps_r + 1'b1;
            state_r <= S_CK_RD;
          end else begin
            victim_r <= hand_r;
            state_r  <= S_V_RD;
          end
        end
        S_V_RD: state_r <= S_V_OWN;
        S_V_OWN: begin
          p_r    <= fm_rsp.prv;
          n_r    <= fm_rsp.nxt;
          ovpn_r <= fm_rsp.own.vpn;
          state_r <= fm_rsp.own.valid ? S_V_OLD : S_V_MAP;
        end
        S_V_OLD: begin
          wbv_r     <= dirty;
          wbvpn_r   <= ovpn_r;
          wbframe_r <= victim_r;
          wbrgn_r   <= old_rgn;
          state_r   <= S_V_MAP;
        end
        S_V_MAP: begin
          tailn_r <= (victim_r == tail_r) ? n_r : tail_r;
          state_r <= S_V_RDT;
        end
        S_V_RDT:  state_r <= S_V_LNK1;
        S_V_LNK1: state_r <= S_V_LNK2;
        S_V_LNK2: begin
          if (out_free) begin
            tail_r  <= victim_r;
            state_r <= S_IDLE;
          end
        end
        S_F_RD: state_r <= S_F_CHK;
        S_F_CHK: begin
          if (dirty) begin
            if (out_free) begin
              fcnt_r <= fcnt_r + 1'b1;
              if (ptr_r == VPN_W'(VPAGES - 1) || fcnt_r == FCNT_W'(FLUSH_MAX - 1)) begin
                state_r <= S_F_DONE;
              end else begin
                ptr_r   <= ptr_r + 1'b1;
                state_r <= S_F_RD;
              end
            end
          end else if (ptr_r == VPN_W'(VPAGES - 1)) begin
            state_r <= S_F_DONE;
          end else begin
            ptr_r   <= ptr_r + 1'b1;
            state_r <= S_F_RD;
          end
        end
        S_F_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/dpm_checker.sv
// Port-level checks for the paging MMU, bound to the top level.
// Depends on dpm_pkg and demand_paging_mmu_with_clock_fifo.
`timescale 1ns / 1ps
module dpm_checker
  import dpm_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input in_item_t         in_data,
  input logic             out_valid,
  input logic             out_ready,
  input out_item_t        out_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input item dropped or changed while waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_HIT || out_data.status == ST_LOAD ||
                  out_data.status == ST_INVAL || out_data.status == ST_DONE)
    |-> out_data.last)
    else $error("single result without last");

  a_flush_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_WB
    |-> !out_data.last && out_data.writeback_valid && out_data.phys_addr == '0)
    else $error("bad flush write-back");

endmodule

bind demand_paging_mmu_with_clock_fifo dpm_checker u_dpm_checker (.*);
